FILE: hdl/dhcpw_pkg.sv
// Package for the DHCP server reply watch block.
// Holds the parser constants, the walk state type and the queue command struct.
package dhcpw_pkg;

  localparam int MAX_SERVERS_DEF = 16;

  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [31:0] PORTS_WORD = 32'h0043_0044;
  localparam logic [31:0] COOKIE     = 32'h6382_5363;
  localparam logic [7:0]  BOOTREPLY  = 8'd2;
  localparam logic [7:0]  OPT_PAD    = 8'd0;
  localparam logic [7:0]  OPT_END    = 8'd255;
  localparam logic [7:0]  OPT_TYPE   = 8'd53;
  localparam logic [7:0]  MSG_OFFER  = 8'd2;
  localparam logic [7:0]  MSG_ACK    = 8'd5;
  localparam logic [15:0] POS_LIMIT  = 16'hFFFF;

  typedef enum logic [4:0] {
    WALK_CODE  = 5'b00001,
    WALK_LEN   = 5'b00010,
    WALK_LEN53 = 5'b00100,
    WALK_TYPE  = 5'b01000,
    WALK_DONE  = 5'b10000
  } walk_t;

  // Command handed from the parser to the table engine.
  typedef struct packed {
    logic        is_read;
    logic [7:0]  read_index;
    logic [31:0] server;
    logic [31:0] offered;
    logic [31:0] now;
    logic        susp;
  } cmd_t;

endpackage

FILE: hdl/dhcpw_front.sv
// Front part: parses packet bytes and emits table commands.
// Depends on dhcpw_pkg.
module dhcpw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        gateway,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [7:0]         in_data_byte,
  input  logic               in_last_byte,
  input  logic [31:0]        in_now_ms,
  input  logic [7:0]         in_read_index,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dhcpw_pkg::cmd_t    cmd
);

  logic [15:0] pos_r, pos_nxt;
  logic [6:0]  hlen_r, hlen_nxt;
  logic        rej_r, rej_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] offd_r, offd_nxt;
  dhcpw_pkg::walk_t walk_r, walk_nxt;
  logic [16:0] onext_r, onext_nxt;
  logic [16:0] tend_r, tend_nxt;
  logic        tok_r, tok_nxt;

  logic        acc, emit;
  logic [16:0] p, d, tot, nx;
  logic        match;
  dhcpw_pkg::cmd_t c;

  assign in_ready = !cmd_valid || cmd_ready;
  assign acc = in_valid && in_ready;
  assign p = {1'b0, pos_r};
  assign d = {10'd0, hlen_r} + 17'd8;

  // Parse one byte, close packet on last
  always_comb begin
    pos_nxt = pos_r; hlen_nxt = hlen_r; rej_nxt = rej_r; shift_nxt = shift_r;
    src_nxt = src_r; offd_nxt = offd_r; walk_nxt = walk_r; onext_nxt = onext_r;
    tend_nxt = tend_r; tok_nxt = tok_r; nx = '0;
    if (pos_r >= dhcpw_pkg::POS_LIMIT) begin
      rej_nxt = 1'b1;
    end else begin
      pos_nxt = pos_r + 16'd1;
      if (!rej_r) begin
        if (pos_r == 16'd0) begin
          hlen_nxt = {1'b0, in_data_byte[3:0], 2'b00};
          if (in_data_byte[7:4] != 4'd4 || in_data_byte[3:0] < 4'd5) rej_nxt = 1'b1;
          onext_nxt = {10'd0, in_data_byte[3:0], 2'b00} + 17'd248;
        end else begin
          if (pos_r == 16'd9 && in_data_byte != dhcpw_pkg::PROTO_UDP) rej_nxt = 1'b1;
          if (pos_r >= 16'd12 && pos_r <= 16'd15) src_nxt = {src_r[23:0], in_data_byte};
          if (p >= {10'd0, hlen_r} && p < {10'd0, hlen_r} + 17'd4) begin
            shift_nxt = {shift_r[23:0], in_data_byte};
            if (p == {10'd0, hlen_r} + 17'd3 && shift_nxt != dhcpw_pkg::PORTS_WORD)
              rej_nxt = 1'b1;
          end
          if (p == d && in_data_byte != dhcpw_pkg::BOOTREPLY) rej_nxt = 1'b1;
          if (p >= d + 17'd16 && p < d + 17'd20) offd_nxt = {offd_r[23:0], in_data_byte};
          if (p >= d + 17'd236 && p < d + 17'd240) begin
            shift_nxt = {shift_r[23:0], in_data_byte};
            if (p == d + 17'd239 && shift_nxt != dhcpw_pkg::COOKIE) rej_nxt = 1'b1;
          end
          if (p >= d + 17'd240 && walk_r != dhcpw_pkg::WALK_DONE && p == onext_r) begin
            unique case (walk_r)
              dhcpw_pkg::WALK_CODE: begin
                if (in_data_byte == dhcpw_pkg::OPT_END) walk_nxt = dhcpw_pkg::WALK_DONE;
                else begin
                  onext_nxt = p + 17'd1;
                  if (in_data_byte == dhcpw_pkg::OPT_TYPE) walk_nxt = dhcpw_pkg::WALK_LEN53;
                  else if (in_data_byte != dhcpw_pkg::OPT_PAD)
                    walk_nxt = dhcpw_pkg::WALK_LEN;
                end
              end
              dhcpw_pkg::WALK_LEN: begin
                onext_nxt = p + 17'd1 + {9'd0, in_data_byte};
                walk_nxt = dhcpw_pkg::WALK_CODE;
              end
              dhcpw_pkg::WALK_LEN53: begin
                nx = p + 17'd1 + {9'd0, in_data_byte};
                if (in_data_byte == 8'd0) begin
                  onext_nxt = p + 17'd1; walk_nxt = dhcpw_pkg::WALK_CODE;
                end else if (nx[16]) walk_nxt = dhcpw_pkg::WALK_DONE;
                else begin
                  tend_nxt = nx; onext_nxt = p + 17'd1; walk_nxt = dhcpw_pkg::WALK_TYPE;
                end
              end
              dhcpw_pkg::WALK_TYPE: begin
                tok_nxt = (in_data_byte == dhcpw_pkg::MSG_OFFER) ||
                          (in_data_byte == dhcpw_pkg::MSG_ACK);
                walk_nxt = dhcpw_pkg::WALK_DONE;
              end
              default: walk_nxt = dhcpw_pkg::WALK_DONE;
            endcase
            if (onext_nxt[16]) walk_nxt = dhcpw_pkg::WALK_DONE;
          end
        end
      end
    end
  end

  assign tot = {1'b0, pos_nxt};
  assign match = !rej_nxt && tot >= d + 17'd240 && tok_nxt && tend_nxt <= tot;
  assign emit = acc && (in_op || (in_last_byte && match));

  always_comb begin
    c.is_read    = in_op;
    c.read_index = in_read_index;
    c.server     = src_nxt;
    c.offered    = offd_nxt;
    c.now        = in_now_ms;
    c.susp       = (gateway != 32'd0) && (src_nxt != gateway);
  end

  // Advance packet state, hold output register until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; hlen_r <= '0; rej_r <= 1'b0; shift_r <= '0; src_r <= '0;
      offd_r <= '0; walk_r <= dhcpw_pkg::WALK_CODE; onext_r <= '0; tend_r <= '0;
      tok_r <= 1'b0; cmd_valid <= 1'b0;
    end else begin
      if (acc && !in_op) begin
        if (in_last_byte) begin
          pos_r <= '0; hlen_r <= '0; rej_r <= 1'b0; shift_r <= '0; src_r <= '0;
          offd_r <= '0; walk_r <= dhcpw_pkg::WALK_CODE; onext_r <= '0;
          tend_r <= '0; tok_r <= 1'b0;
        end else begin
          pos_r <= pos_nxt; hlen_r <= hlen_nxt; rej_r <= rej_nxt; shift_r <= shift_nxt;
          src_r <= src_nxt; offd_r <= offd_nxt; walk_r <= walk_nxt;
          onext_r <= onext_nxt; tend_r <= tend_nxt; tok_r <= tok_nxt;
        end
      end
      if (emit) cmd_valid <= 1'b1;
      else if (cmd_ready) cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) cmd <= c;
  end

endmodule

FILE: hdl/dhcpw_fifo.sv
// Short queue between parser and table engine.
// Depends on dhcpw_pkg.
module dhcpw_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  dhcpw_pkg::cmd_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output dhcpw_pkg::cmd_t rd_data
);

  dhcpw_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  // Move pointers on each handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_valid && wr_ready) wp_r <= ~wp_r;
      if (rd_valid && rd_ready) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem_r[wp_r] <= wr_data;
  end

endmodule

FILE: hdl/dhcpw_table.sv
// Back part: server table search, update, insert and read.
// Depends on dhcpw_pkg.
module dhcpw_table #(
  parameter int MAX_SERVERS = dhcpw_pkg::MAX_SERVERS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  dhcpw_pkg::cmd_t cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_is_read_reply,
  output logic            out_entry_valid,
  output logic [31:0]     out_server_address,
  output logic [31:0]     out_offered_address,
  output logic [31:0]     out_last_seen_ms,
  output logic            out_suspicious,
  output logic            out_newly_added,
  output logic            out_table_full_drop,
  output logic [8:0]      out_entry_count
);

  localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [8:0] MAXC = 9'(MAX_SERVERS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_READ = 4'b0100, S_OUT = 4'b1000
  } st_t;

  logic [31:0] srv_m [MAX_SERVERS];
  logic [31:0] off_m [MAX_SERVERS];
  logic [31:0] see_m [MAX_SERVERS];
  logic        sus_m [MAX_SERVERS];

  st_t st_r;
  dhcpw_pkg::cmd_t c_r;
  logic [8:0]  used_r, k_r;
  logic [31:0] rsrv_r, roff_r, rsee_r;
  logic        rsus_r;
  logic [IW-1:0] raddr;

  assign cmd_ready = st_r == S_IDLE;

  // Address the entry for a read, the first entry of a scan, or the next scan entry
  always_comb begin
    if (st_r == S_IDLE && cmd.is_read) raddr = IW'(used_r - 9'd1 - {1'b0, cmd.read_index});
    else if (st_r == S_IDLE) raddr = '0;
    else raddr = IW'(k_r + 9'd1);
  end

  // Registered table read
  always_ff @(posedge clk) begin
    rsrv_r <= srv_m[raddr]; roff_r <= off_m[raddr];
    rsee_r <= see_m[raddr]; rsus_r <= sus_m[raddr];
  end

  // Sequence one command: read or scan, then present result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; used_r <= '0; k_r <= '0; out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (cmd_valid) begin
          c_r <= cmd; k_r <= '0;
          st_r <= cmd.is_read ? S_READ : S_SCAN;
        end
        S_READ: begin
          out_is_read_reply <= 1'b1;
          out_newly_added <= 1'b0; out_table_full_drop <= 1'b0;
          out_entry_count <= used_r;
          if ({1'b0, c_r.read_index} < used_r) begin
            out_entry_valid <= 1'b1; out_server_address <= rsrv_r;
            out_offered_address <= roff_r; out_last_seen_ms <= rsee_r;
            out_suspicious <= rsus_r;
          end else begin
            out_entry_valid <= 1'b0; out_server_address <= '0;
            out_offered_address <= '0; out_last_seen_ms <= '0; out_suspicious <= 1'b0;
          end
          out_valid <= 1'b1; st_r <= S_OUT;
        end
        S_SCAN: begin
          out_is_read_reply <= 1'b0; out_server_address <= c_r.server;
          out_offered_address <= c_r.offered; out_last_seen_ms <= c_r.now;
          out_suspicious <= c_r.susp;
          if (k_r < used_r && rsrv_r == c_r.server) begin
            off_m[IW'(k_r)] <= c_r.offered; see_m[IW'(k_r)] <= c_r.now;
            sus_m[IW'(k_r)] <= c_r.susp;
            out_entry_valid <= 1'b1; out_newly_added <= 1'b0;
            out_table_full_drop <= 1'b0; out_entry_count <= used_r;
            out_valid <= 1'b1; st_r <= S_OUT;
          end else if (k_r + 9'd1 < used_r) begin
            k_r <= k_r + 9'd1;
          end else if (used_r < MAXC) begin
            srv_m[IW'(used_r)] <= c_r.server; off_m[IW'(used_r)] <= c_r.offered;
            see_m[IW'(used_r)] <= c_r.now; sus_m[IW'(used_r)] <= c_r.susp;
            used_r <= used_r + 9'd1;
            out_entry_valid <= 1'b1; out_newly_added <= 1'b1;
            out_table_full_drop <= 1'b0; out_entry_count <= used_r + 9'd1;
            out_valid <= 1'b1; st_r <= S_OUT;
          end else begin
            out_entry_valid <= 1'b0; out_newly_added <= 1'b0;
            out_table_full_drop <= 1'b1; out_entry_count <= used_r;
            out_valid <= 1'b1; st_r <= S_OUT;
          end
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/dhcp_server_reply_watch_core.sv
// Top level of the DHCP server reply watch block.
// Depends on dhcpw_pkg, dhcpw_front, dhcpw_fifo and dhcpw_table.
//
//  channel | handshake            | payload
//  in_     | in_valid / in_ready  | op, data_byte, last_byte, now_ms, read_index
//  out_    | out_valid / out_ready| is_read_reply .. entry_count
//  cfg_    | cfg_wr_en            | cfg_gateway_address
//
// Packet bytes are taken one a cycle by the parser when it is not stalled. A
// matching packet end or a read goes through a two-entry queue to the table
// engine, which serves a read with a single table read and a reply with one
// scan step per entry compared (at least one step), set by its single table
// read port. Reset is synchronous; the table needs no clear.
// The parser stalls only when its output register and the queue are full.
module dhcp_server_reply_watch_core #(
  parameter int MAX_SERVERS = dhcpw_pkg::MAX_SERVERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_gateway_address,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_read_reply,
  output logic        out_entry_valid,
  output logic [31:0] out_server_address,
  output logic [31:0] out_offered_address,
  output logic [31:0] out_last_seen_ms,
  output logic        out_suspicious,
  output logic        out_newly_added,
  output logic        out_table_full_drop,
  output logic [8:0]  out_entry_count
);

  logic [31:0] gw_r;
  logic f_valid, f_ready, q_valid, q_ready;
  dhcpw_pkg::cmd_t f_cmd, q_cmd;

  // Hold the gateway register
  always_ff @(posedge clk) begin
    if (!rst_n) gw_r <= '0;
    else if (cfg_wr_en) gw_r <= cfg_gateway_address;
  end

  dhcpw_front u_front (
    .clk, .rst_n, .gateway(gw_r), .in_valid, .in_ready, .in_op, .in_data_byte,
    .in_last_byte, .in_now_ms, .in_read_index,
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  dhcpw_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  dhcpw_table #(.MAX_SERVERS(MAX_SERVERS)) u_table (
    .clk, .rst_n, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid, .out_ready, .out_is_read_reply, .out_entry_valid,
    .out_server_address, .out_offered_address, .out_last_seen_ms,
    .out_suspicious, .out_newly_added, .out_table_full_drop, .out_entry_count
  );

endmodule

FILE: hdl/dhcpw_checker.sv
// Port checker for the DHCP server reply watch block, with its bind.
// Depends on dhcp_server_reply_watch_core ports only.
module dhcpw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_read_reply,
  input logic        out_entry_valid,
  input logic        out_newly_added,
  input logic        out_table_full_drop,
  input logic [8:0]  out_entry_count,
  input logic [31:0] out_server_address
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_server_address))
    else $error("result dropped while stalled");

  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_read_reply |-> !out_newly_added && !out_table_full_drop)
    else $error("read result carries reply flags");

  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full_drop |-> !out_entry_valid && !out_newly_added)
    else $error("dropped reply marked stored");

  a_added_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_newly_added |-> out_entry_count != 9'd0)
    else $error("insert with zero count");

endmodule

bind dhcp_server_reply_watch_core dhcpw_checker u_chk (.*);
